FILE: src/fsc_pkg.sv
// ----------------------------------------------------------------------------
// fsc_pkg
// shared types and constants of the file signature classifier
// ----------------------------------------------------------------------------
package fsc_pkg;

  // default number of bytes taken before the verdict
  localparam int HEADER_BYTES_DEF = 36;
  // header bytes that any signature looks at
  localparam int SIG_BYTES        = 36;
  localparam int TYPE_COUNT       = 34;
  localparam int TYPE_W           = 6;

  typedef logic [7:0] hdr_byte_t;
  typedef hdr_byte_t [SIG_BYTES-1:0] hdr_view_t;

  typedef struct packed {
    logic              found;
    logic [TYPE_W-1:0] type_index;
  } fsc_result_t;

  // table positions, in priority order
  localparam logic [TYPE_W-1:0] TY_WAV      = 6'd0;
  localparam logic [TYPE_W-1:0] TY_FLAC     = 6'd1;
  localparam logic [TYPE_W-1:0] TY_OGG      = 6'd2;
  localparam logic [TYPE_W-1:0] TY_OPUS     = 6'd3;
  localparam logic [TYPE_W-1:0] TY_MP3      = 6'd4;
  localparam logic [TYPE_W-1:0] TY_AAC      = 6'd5;
  localparam logic [TYPE_W-1:0] TY_M4A      = 6'd6;
  localparam logic [TYPE_W-1:0] TY_AIFF     = 6'd7;
  localparam logic [TYPE_W-1:0] TY_MP4      = 6'd8;
  localparam logic [TYPE_W-1:0] TY_WEBM     = 6'd9;
  localparam logic [TYPE_W-1:0] TY_MKV      = 6'd10;
  localparam logic [TYPE_W-1:0] TY_M4V      = 6'd11;
  localparam logic [TYPE_W-1:0] TY_3GP      = 6'd12;
  localparam logic [TYPE_W-1:0] TY_3G2      = 6'd13;
  localparam logic [TYPE_W-1:0] TY_MOV      = 6'd14;
  localparam logic [TYPE_W-1:0] TY_FLV      = 6'd15;
  localparam logic [TYPE_W-1:0] TY_MPEG     = 6'd16;
  localparam logic [TYPE_W-1:0] TY_AVI      = 6'd17;
  localparam logic [TYPE_W-1:0] TY_TTF      = 6'd18;
  localparam logic [TYPE_W-1:0] TY_OTF      = 6'd19;
  localparam logic [TYPE_W-1:0] TY_WOFF2    = 6'd20;
  localparam logic [TYPE_W-1:0] TY_WOFF     = 6'd21;
  localparam logic [TYPE_W-1:0] TY_PNG      = 6'd22;
  localparam logic [TYPE_W-1:0] TY_WEBP     = 6'd23;
  localparam logic [TYPE_W-1:0] TY_AVIF     = 6'd24;
  localparam logic [TYPE_W-1:0] TY_JPEG     = 6'd25;
  localparam logic [TYPE_W-1:0] TY_JPEG2000 = 6'd26;
  localparam logic [TYPE_W-1:0] TY_JPEGXL   = 6'd27;
  localparam logic [TYPE_W-1:0] TY_JPEGXS   = 6'd28;
  localparam logic [TYPE_W-1:0] TY_JPEGXR   = 6'd29;
  localparam logic [TYPE_W-1:0] TY_QOI      = 6'd30;
  localparam logic [TYPE_W-1:0] TY_EXR      = 6'd31;
  localparam logic [TYPE_W-1:0] TY_BMP      = 6'd32;
  localparam logic [TYPE_W-1:0] TY_TIFF     = 6'd33;

endpackage

FILE: src/file_signature_classifier_top.sv
// ----------------------------------------------------------------------------
// file_signature_classifier_top
// classifies a file by its magic number from the first header bytes
// ----------------------------------------------------------------------------
// usage:
//   in channel: one file byte per word (in_data_byte), in file order, with
//   in_end_of_file set on the file's last byte. words of the next file may
//   follow directly in the next cycle
//   out channel: one word per file (out_found, out_type_index); the verdict
//   is taken on the HEADER_BYTES-th byte or on an earlier last byte, bytes
//   after the verdict are dropped up to the end of file
// timing: the result word is registered, valid in the cycle after the byte that
//   closes the header is accepted
// throughput: one byte per cycle while in_ready is high; the compare is a
//   single pass of parallel logic between the header flops and the result register
// stall: out holds in a result register; while it is full and not taken,
//   in_ready drops, so at most one result waits
// reset: synchronous, active low; clears the fill count, the verdict flag
//   and the result valid. header flops are not cleared, entries beyond
//   the fill count read as zero
// ----------------------------------------------------------------------------
module file_signature_classifier_top #(
  parameter int HEADER_BYTES = fsc_pkg::HEADER_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_end_of_file,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_found,
  output logic [fsc_pkg::TYPE_W-1:0] out_type_index
);

  localparam int POS_W = $clog2(HEADER_BYTES);
  localparam int IDX_W = $clog2(fsc_pkg::SIG_BYTES);

  // header flops, only the bytes the signatures look at
  fsc_pkg::hdr_byte_t  store_r [fsc_pkg::SIG_BYTES];
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                given_r, given_nxt;
  logic                out_valid_r, out_valid_nxt;
  fsc_pkg::fsc_result_t res_r, res;
  fsc_pkg::hdr_view_t  view;

  logic in_fire, last_hdr, fire, store_wr;

  // accept while the result register is empty or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign last_hdr = (pos_r == POS_W'(HEADER_BYTES - 1));
  // verdict on this word
  assign fire     = in_fire && !given_r && (last_hdr || in_end_of_file);
  assign store_wr = in_fire && !given_r && (pos_r < POS_W'(fsc_pkg::SIG_BYTES));

  // header as seen including the byte arriving now; unfilled slots read zero
  always_comb begin
    for (int i = 0; i < fsc_pkg::SIG_BYTES; i++) begin
      if (pos_r > POS_W'(i)) begin
        view[i] = store_r[i];
      end else if (pos_r == POS_W'(i)) begin
        view[i] = in_data_byte;
      end else begin
        view[i] = '0;
      end
    end
  end

  fsc_classify u_classify (
    .hdr (view),
    .res (res)
  );

  // fill count and verdict flag; end of file starts a fresh file
  always_comb begin
    pos_nxt   = pos_r;
    given_nxt = given_r;
    if (in_fire) begin
      if (in_end_of_file) begin
        pos_nxt   = '0;
        given_nxt = 1'b0;
      end else if (!given_r) begin
        if (last_hdr) begin
          given_nxt = 1'b1;
        end else begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      given_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      given_r     <= given_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_wr) begin
      store_r[pos_r[IDX_W-1:0]] <= in_data_byte;
    end
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = res_r.found;
  assign out_type_index = res_r.type_index;

  // not found always reports position zero
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.found |-> res_r.type_index == '0)
    else $error("not-found result with nonzero type index");

  // ogg shadows opus, and no position past the table
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> res_r.type_index != fsc_pkg::TY_OPUS &&
                    res_r.type_index < fsc_pkg::TYPE_W'(fsc_pkg::TYPE_COUNT))
    else $error("type index out of reachable range");

  // a full header always produces a result word
  a_full_header: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !given_r && last_hdr |=> out_valid_r && given_r == !$past(in_end_of_file))
    else $error("full header gave no result");

  // end of file resets the per-file state
  a_eof_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_end_of_file |=> pos_r == '0 && !given_r)
    else $error("file state not cleared at end of file");

  // fill count stays still once the verdict is out
  a_hold_pos: assert property (@(posedge clk) disable iff (!rst_n)
    given_r && !(in_fire && in_end_of_file) |=> $stable(pos_r))
    else $error("fill count moved after verdict");

endmodule

FILE: src/fsc_classify.sv
// ----------------------------------------------------------------------------
// fsc_classify
// parallel signature compare and priority pick over the header view
// ----------------------------------------------------------------------------
module fsc_classify (
  input  fsc_pkg::hdr_view_t   hdr,
  output fsc_pkg::fsc_result_t res
);

  logic [fsc_pkg::TYPE_COUNT-1:0] m;
  logic ftyp, riff, ebml, ogg, mp4_brand;

  function automatic logic [15:0] w2(input fsc_pkg::hdr_view_t h, input int off);
    return {h[off], h[off+1]};
  endfunction

  function automatic logic [23:0] w3(input fsc_pkg::hdr_view_t h, input int off);
    return {h[off], h[off+1], h[off+2]};
  endfunction

  function automatic logic [31:0] w4(input fsc_pkg::hdr_view_t h, input int off);
    return {h[off], h[off+1], h[off+2], h[off+3]};
  endfunction

  function automatic logic [63:0] w8(input fsc_pkg::hdr_view_t h, input int off);
    return {w4(h, off), w4(h, off + 4)};
  endfunction

  function automatic logic [95:0] w12(input fsc_pkg::hdr_view_t h, input int off);
    return {w4(h, off), w4(h, off + 4), w4(h, off + 8)};
  endfunction

  always_comb begin
    ftyp = (w4(hdr, 4) == 32'h66747970);
    riff = (w4(hdr, 0) == 32'h52494646);
    ebml = (w4(hdr, 0) == 32'h1A45DFA3);
    ogg  = (w4(hdr, 0) == 32'h4F676753);
    mp4_brand = (w4(hdr, 8) == 32'h61766331) || (w4(hdr, 8) == 32'h64617368) ||
                (w4(hdr, 8) == 32'h69736F6D) || (w4(hdr, 8) == 32'h69736F32) ||
                (w4(hdr, 8) == 32'h6D703432) || (w4(hdr, 8) == 32'h6D703731) ||
                (w4(hdr, 8) == 32'h6D6D7034) || (w4(hdr, 8) == 32'h6D703476) ||
                (w4(hdr, 8) == 32'h4D534E56);

    m = '0;
    m[fsc_pkg::TY_WAV]   = riff && (w4(hdr, 8) == 32'h57415645);
    m[fsc_pkg::TY_FLAC]  = (w4(hdr, 0) == 32'h664C6143);
    m[fsc_pkg::TY_OGG]   = ogg;
    m[fsc_pkg::TY_OPUS]  = ogg && (w8(hdr, 28) == 64'h4F70757348656164);
    m[fsc_pkg::TY_MP3]   = (w3(hdr, 0) == 24'h494433) ||
                           (hdr[0] == 8'hFF && (hdr[1] == 8'hFB || hdr[1] == 8'hF3 ||
                                                hdr[1] == 8'hF2));
    m[fsc_pkg::TY_AAC]   = hdr[0] == 8'hFF && (hdr[1] == 8'hF1 || hdr[1] == 8'hF9);
    m[fsc_pkg::TY_M4A]   = ftyp && (w2(hdr, 8) == 16'h4D34) &&
                           (hdr[10] == 8'h41 || hdr[10] == 8'h42 || hdr[10] == 8'h50);
    m[fsc_pkg::TY_AIFF]  = (w4(hdr, 0) == 32'h464F524D) && (w4(hdr, 8) == 32'h41494646);
    m[fsc_pkg::TY_MP4]   = ftyp && mp4_brand;
    m[fsc_pkg::TY_WEBM]  = ebml && (w4(hdr, 24) == 32'h7765626D);
    m[fsc_pkg::TY_MKV]   = ebml && (w8(hdr, 24) == 64'h6D6174726F736B61);
    m[fsc_pkg::TY_M4V]   = ftyp && (w4(hdr, 8) == 32'h4D345620);
    m[fsc_pkg::TY_3GP]   = ftyp && (w3(hdr, 8) == 24'h336770);
    m[fsc_pkg::TY_3G2]   = ftyp && (w3(hdr, 8) == 24'h336732);
    m[fsc_pkg::TY_MOV]   = (ftyp && (w4(hdr, 8) == 32'h71742020)) ||
                           (w4(hdr, 4) == 32'h6D6F6F76) || (w4(hdr, 4) == 32'h66726565);
    m[fsc_pkg::TY_FLV]   = (w3(hdr, 0) == 24'h464C56);
    m[fsc_pkg::TY_MPEG]  = (w3(hdr, 0) == 24'h000001) && (hdr[3][7:4] == 4'hB);
    m[fsc_pkg::TY_AVI]   = riff && (w3(hdr, 8) == 24'h415649);
    m[fsc_pkg::TY_TTF]   = (w4(hdr, 0) == 32'h00010000) && (hdr[4] == 8'h00);
    m[fsc_pkg::TY_OTF]   = (w4(hdr, 0) == 32'h4F54544F);
    m[fsc_pkg::TY_WOFF2] = (w8(hdr, 0) == 64'h774F463200010000);
    m[fsc_pkg::TY_WOFF]  = (w8(hdr, 0) == 64'h774F464600010000);
    m[fsc_pkg::TY_PNG]   = (w8(hdr, 0) == 64'h89504E470D0A1A0A);
    m[fsc_pkg::TY_WEBP]  = riff && (w4(hdr, 8) == 32'h57454250);
    m[fsc_pkg::TY_AVIF]  = ftyp && (w4(hdr, 8) == 32'h61766966);
    m[fsc_pkg::TY_JPEG]  = (w3(hdr, 0) == 24'hFFD8FF);
    m[fsc_pkg::TY_JPEG2000] = (w4(hdr, 0) == 32'hFF4FFF51) ||
                              (w12(hdr, 0) == 96'h0000000C6A5020200D0A870A);
    m[fsc_pkg::TY_JPEGXL] = (w2(hdr, 0) == 16'hFF0A) ||
                            (w12(hdr, 0) == 96'h0000000C4A584C200D0A870A);
    m[fsc_pkg::TY_JPEGXS] = (w4(hdr, 0) == 32'hFF10FF50);
    m[fsc_pkg::TY_JPEGXR] = (w4(hdr, 0) == 32'h4949BC01);
    m[fsc_pkg::TY_QOI]   = (w4(hdr, 0) == 32'h716F6966);
    m[fsc_pkg::TY_EXR]   = (w4(hdr, 0) == 32'h762F3101);
    m[fsc_pkg::TY_BMP]   = (w2(hdr, 0) == 16'h424D);
    m[fsc_pkg::TY_TIFF]  = (w4(hdr, 0) == 32'h49492A00) || (w4(hdr, 0) == 32'h4D4D002A);
  end

  // lowest table position wins
  always_comb begin
    res = '0;
    for (int i = fsc_pkg::TYPE_COUNT - 1; i >= 0; i--) begin
      if (m[i]) begin
        res.found      = 1'b1;
        res.type_index = fsc_pkg::TYPE_W'(i);
      end
    end
  end

endmodule

FILE: tb/sv/fsc_verdict_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fsc_verdict_checker
// watches both channels of the file signature classifier, predicts the
// verdict of every file from the accepted bytes and compares each result word
// ----------------------------------------------------------------------------
module fsc_verdict_checker #(
  parameter int HEADER_BYTES = fsc_pkg::HEADER_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_end_of_file,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       out_found,
  input  logic [fsc_pkg::TYPE_W-1:0] out_type_index,
  output int                         mismatch_count,
  output int                         verdicts_pending
);

  // predicted header store, fill count and verdict flag
  logic [7:0]  hdr [0:HEADER_BYTES-1];
  int unsigned fill_count;
  bit          verdict_done;

  fsc_pkg::fsc_result_t expected_verdicts [$];

  initial begin
    mismatch_count   = 0;
    verdicts_pending = 0;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic clear_header();
    for (int i = 0; i < HEADER_BYTES; i++) hdr[i] = 8'h00;
    fill_count   = 0;
    verdict_done = 0;
  endtask

  // true when the n bytes of pat, first byte in the top lane, sit at off
  function automatic bit hdr_has(int off, logic [95:0] pat, int n);
    for (int k = 0; k < n; k++) begin
      if (hdr[off+k] != pat[8*(n-1-k) +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit sig_hit(logic [fsc_pkg::TYPE_W-1:0] id);
    bit ftyp;
    bit riff;
    bit ebml;
    ftyp = hdr_has(4, 32'h66747970, 4);
    riff = hdr_has(0, 32'h52494646, 4);
    ebml = hdr_has(0, 32'h1A45DFA3, 4);
    case (id)
      fsc_pkg::TY_WAV:
        return riff && hdr_has(8, 32'h57415645, 4);
      fsc_pkg::TY_FLAC:
        return hdr_has(0, 32'h664C6143, 4);
      fsc_pkg::TY_OGG:
        return hdr_has(0, 32'h4F676753, 4);
      fsc_pkg::TY_OPUS:
        return hdr_has(0, 32'h4F676753, 4) && hdr_has(28, 64'h4F70757348656164, 8);
      fsc_pkg::TY_MP3:
        return hdr_has(0, 24'h494433, 3) ||
               (hdr[0] == 8'hFF &&
                (hdr[1] == 8'hFB || hdr[1] == 8'hF3 || hdr[1] == 8'hF2));
      fsc_pkg::TY_AAC:
        return hdr[0] == 8'hFF && (hdr[1] == 8'hF1 || hdr[1] == 8'hF9);
      fsc_pkg::TY_M4A:
        return ftyp && hdr[8] == 8'h4D && hdr[9] == 8'h34 &&
               (hdr[10] == 8'h41 || hdr[10] == 8'h42 || hdr[10] == 8'h50);
      fsc_pkg::TY_AIFF:
        return hdr_has(0, 32'h464F524D, 4) && hdr_has(8, 32'h41494646, 4);
      fsc_pkg::TY_MP4:
        return ftyp &&
               (hdr_has(8, 32'h61766331, 4) || hdr_has(8, 32'h64617368, 4) ||
                hdr_has(8, 32'h69736F6D, 4) || hdr_has(8, 32'h69736F32, 4) ||
                hdr_has(8, 32'h6D703432, 4) || hdr_has(8, 32'h6D703731, 4) ||
                hdr_has(8, 32'h6D6D7034, 4) || hdr_has(8, 32'h6D703476, 4) ||
                hdr_has(8, 32'h4D534E56, 4));
      fsc_pkg::TY_WEBM:
        return ebml && hdr_has(24, 32'h7765626D, 4);
      fsc_pkg::TY_MKV:
        return ebml && hdr_has(24, 64'h6D6174726F736B61, 8);
      fsc_pkg::TY_M4V:
        return ftyp && hdr_has(8, 32'h4D345620, 4);
      fsc_pkg::TY_3GP:
        return ftyp && hdr_has(8, 24'h336770, 3);
      fsc_pkg::TY_3G2:
        return ftyp && hdr_has(8, 24'h336732, 3);
      fsc_pkg::TY_MOV:
        return (ftyp && hdr_has(8, 32'h71742020, 4)) ||
               hdr_has(4, 32'h6D6F6F76, 4) || hdr_has(4, 32'h66726565, 4);
      fsc_pkg::TY_FLV:
        return hdr_has(0, 24'h464C56, 3);
      fsc_pkg::TY_MPEG:
        return hdr_has(0, 24'h000001, 3) && hdr[3] >= 8'hB0 && hdr[3] <= 8'hBF;
      fsc_pkg::TY_AVI:
        return riff && hdr_has(8, 24'h415649, 3);
      fsc_pkg::TY_TTF:
        return hdr_has(0, 40'h0001000000, 5);
      fsc_pkg::TY_OTF:
        return hdr_has(0, 32'h4F54544F, 4);
      fsc_pkg::TY_WOFF2:
        return hdr_has(0, 64'h774F463200010000, 8);
      fsc_pkg::TY_WOFF:
        return hdr_has(0, 64'h774F464600010000, 8);
      fsc_pkg::TY_PNG:
        return hdr_has(0, 64'h89504E470D0A1A0A, 8);
      fsc_pkg::TY_WEBP:
        return riff && hdr_has(8, 32'h57454250, 4);
      fsc_pkg::TY_AVIF:
        return ftyp && hdr_has(8, 32'h61766966, 4);
      fsc_pkg::TY_JPEG:
        return hdr_has(0, 24'hFFD8FF, 3);
      fsc_pkg::TY_JPEG2000:
        return hdr_has(0, 32'hFF4FFF51, 4) ||
               hdr_has(0, 96'h0000000C6A5020200D0A870A, 12);
      fsc_pkg::TY_JPEGXL:
        return hdr_has(0, 16'hFF0A, 2) ||
               hdr_has(0, 96'h0000000C4A584C200D0A870A, 12);
      fsc_pkg::TY_JPEGXS:
        return hdr_has(0, 32'hFF10FF50, 4);
      fsc_pkg::TY_JPEGXR:
        return hdr_has(0, 32'h4949BC01, 4);
      fsc_pkg::TY_QOI:
        return hdr_has(0, 32'h716F6966, 4);
      fsc_pkg::TY_EXR:
        return hdr_has(0, 32'h762F3101, 4);
      fsc_pkg::TY_BMP:
        return hdr_has(0, 16'h424D, 2);
      fsc_pkg::TY_TIFF:
        return hdr_has(0, 32'h49492A00, 4) || hdr_has(0, 32'h4D4D002A, 4);
      default:
        return 1'b0;
    endcase
  endfunction

  // first table entry that matches wins
  function automatic fsc_pkg::fsc_result_t classify_header();
    fsc_pkg::fsc_result_t r;
    r = '0;
    for (int i = 0; i < fsc_pkg::TYPE_COUNT; i++) begin
      if (sig_hit(fsc_pkg::TYPE_W'(i))) begin
        r.found      = 1'b1;
        r.type_index = fsc_pkg::TYPE_W'(i);
        return r;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    fsc_pkg::fsc_result_t want;
    if (!rst_n) begin
      clear_header();
      expected_verdicts.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("result word with no file pending, found %0d type %0d",
                                    out_found, out_type_index));
        end else begin
          want = expected_verdicts.pop_front();
          if (out_found !== want.found)
            report_mismatch($sformatf("found got %0d expected %0d", out_found, want.found));
          if (out_type_index !== want.type_index)
            report_mismatch($sformatf("type_index got %0d expected %0d",
                                      out_type_index, want.type_index));
        end
      end
      if (in_valid && in_ready) begin
        if (!verdict_done) begin
          if (fill_count < HEADER_BYTES) begin
            hdr[fill_count] = in_data_byte;
            fill_count++;
          end
          if (fill_count >= HEADER_BYTES || in_end_of_file) begin
            expected_verdicts.push_back(classify_header());
            verdict_done = 1'b1;
          end
        end
        if (in_end_of_file) clear_header();
      end
    end
    verdicts_pending <= expected_verdicts.size();
  end

endmodule

FILE: tb/sv/tb_file_signature_classifier_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_file_signature_classifier_top
// streams files built around magic numbers, corrupted magic numbers and noise
// into the classifier, with random gaps and stalls; a checker beside the
// block predicts each verdict and this module gives the final verdict
// ----------------------------------------------------------------------------
module tb_file_signature_classifier_top;

  localparam int HDR_LEN     = fsc_pkg::HEADER_BYTES_DEF;
  localparam int BYTE_GOAL   = 650;  // random stimulus stops after this many bytes
  localparam int FILE_GOAL   = 20;   // and after at least this many files
  localparam int QUIET_LIMIT = 100;  // cycles without any handshake before giving up
  localparam int TAIL_CYCLES = 8;    // settle time after the last verdict

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [7:0]                 in_data_byte;
  logic                       in_end_of_file;
  logic                       out_valid;
  logic                       out_ready;
  logic                       out_found;
  logic [fsc_pkg::TYPE_W-1:0] out_type_index;

  int mismatch_count;
  int verdicts_pending;
  int quiet_cycles;
  int bytes_sent;

  // file under construction
  logic [7:0] fbuf [0:63];
  int         flen;
  bit         in_burst;   // no gaps between words of this file
  bit         out_burst;  // no stalls on result words for a stretch

  file_signature_classifier_top #(
    .HEADER_BYTES (HDR_LEN)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_end_of_file (in_end_of_file),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_type_index (out_type_index)
  );

  fsc_verdict_checker #(
    .HEADER_BYTES (HDR_LEN)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_file   (in_end_of_file),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_type_index   (out_type_index),
    .mismatch_count   (mismatch_count),
    .verdicts_pending (verdicts_pending)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // write the n bytes of pat, first byte in the top lane, at off
  task automatic put_bytes(int off, logic [95:0] pat, int n);
    for (int k = 0; k < n; k++) fbuf[off+k] = pat[8*(n-1-k) +: 8];
  endtask

  // lay a well-formed magic number for table entry id over the buffer;
  // minlen is the shortest file that still holds the whole pattern
  task automatic put_signature(logic [fsc_pkg::TYPE_W-1:0] id, output int minlen);
    bit alt;
    alt = $urandom_range(0, 1);
    case (id)
      fsc_pkg::TY_WAV: begin
        put_bytes(0, 32'h52494646, 4); put_bytes(8, 32'h57415645, 4); minlen = 12;
      end
      fsc_pkg::TY_FLAC: begin put_bytes(0, 32'h664C6143, 4); minlen = 4; end
      fsc_pkg::TY_OGG:  begin put_bytes(0, 32'h4F676753, 4); minlen = 4; end
      fsc_pkg::TY_OPUS: begin
        // an opus stream is an ogg stream too, ogg has priority
        put_bytes(0, 32'h4F676753, 4); put_bytes(28, 64'h4F70757348656164, 8); minlen = 36;
      end
      fsc_pkg::TY_MP3: begin
        if (alt) begin
          put_bytes(0, 24'h494433, 3); minlen = 3;
        end else begin
          fbuf[0] = 8'hFF;
          case ($urandom_range(0, 2))
            0: fbuf[1] = 8'hFB;
            1: fbuf[1] = 8'hF3;
            default: fbuf[1] = 8'hF2;
          endcase
          minlen = 2;
        end
      end
      fsc_pkg::TY_AAC: begin
        fbuf[0] = 8'hFF; fbuf[1] = alt ? 8'hF1 : 8'hF9; minlen = 2;
      end
      fsc_pkg::TY_M4A: begin
        put_bytes(4, 32'h66747970, 4); put_bytes(8, 16'h4D34, 2);
        case ($urandom_range(0, 2))
          0: fbuf[10] = 8'h41;
          1: fbuf[10] = 8'h42;
          default: fbuf[10] = 8'h50;
        endcase
        minlen = 11;
      end
      fsc_pkg::TY_AIFF: begin
        put_bytes(0, 32'h464F524D, 4); put_bytes(8, 32'h41494646, 4); minlen = 12;
      end
      fsc_pkg::TY_MP4: begin
        put_bytes(4, 32'h66747970, 4);
        case ($urandom_range(0, 8))
          0: put_bytes(8, 32'h61766331, 4);
          1: put_bytes(8, 32'h64617368, 4);
          2: put_bytes(8, 32'h69736F6D, 4);
          3: put_bytes(8, 32'h69736F32, 4);
          4: put_bytes(8, 32'h6D703432, 4);
          5: put_bytes(8, 32'h6D703731, 4);
          6: put_bytes(8, 32'h6D6D7034, 4);
          7: put_bytes(8, 32'h6D703476, 4);
          default: put_bytes(8, 32'h4D534E56, 4);
        endcase
        minlen = 12;
      end
      fsc_pkg::TY_WEBM: begin
        put_bytes(0, 32'h1A45DFA3, 4); put_bytes(24, 32'h7765626D, 4); minlen = 28;
      end
      fsc_pkg::TY_MKV: begin
        put_bytes(0, 32'h1A45DFA3, 4); put_bytes(24, 64'h6D6174726F736B61, 8); minlen = 32;
      end
      fsc_pkg::TY_M4V: begin
        put_bytes(4, 32'h66747970, 4); put_bytes(8, 32'h4D345620, 4); minlen = 12;
      end
      fsc_pkg::TY_3GP: begin
        put_bytes(4, 32'h66747970, 4); put_bytes(8, 24'h336770, 3); minlen = 11;
      end
      fsc_pkg::TY_3G2: begin
        put_bytes(4, 32'h66747970, 4); put_bytes(8, 24'h336732, 3); minlen = 11;
      end
      fsc_pkg::TY_MOV: begin
        case ($urandom_range(0, 2))
          0: begin
            put_bytes(4, 32'h66747970, 4); put_bytes(8, 32'h71742020, 4); minlen = 12;
          end
          1: begin put_bytes(4, 32'h6D6F6F76, 4); minlen = 8; end
          default: begin put_bytes(4, 32'h66726565, 4); minlen = 8; end
        endcase
      end
      fsc_pkg::TY_FLV: begin put_bytes(0, 24'h464C56, 3); minlen = 3; end
      fsc_pkg::TY_MPEG: begin
        put_bytes(0, 24'h000001, 3); fbuf[3] = 8'hB0 | 8'($urandom_range(0, 15)); minlen = 4;
      end
      fsc_pkg::TY_AVI: begin
        put_bytes(0, 32'h52494646, 4); put_bytes(8, 24'h415649, 3); minlen = 11;
      end
      fsc_pkg::TY_TTF:   begin put_bytes(0, 40'h0001000000, 5); minlen = 5; end
      fsc_pkg::TY_OTF:   begin put_bytes(0, 32'h4F54544F, 4); minlen = 4; end
      fsc_pkg::TY_WOFF2: begin put_bytes(0, 64'h774F463200010000, 8); minlen = 8; end
      fsc_pkg::TY_WOFF:  begin put_bytes(0, 64'h774F464600010000, 8); minlen = 8; end
      fsc_pkg::TY_PNG:   begin put_bytes(0, 64'h89504E470D0A1A0A, 8); minlen = 8; end
      fsc_pkg::TY_WEBP: begin
        put_bytes(0, 32'h52494646, 4); put_bytes(8, 32'h57454250, 4); minlen = 12;
      end
      fsc_pkg::TY_AVIF: begin
        put_bytes(4, 32'h66747970, 4); put_bytes(8, 32'h61766966, 4); minlen = 12;
      end
      fsc_pkg::TY_JPEG: begin put_bytes(0, 24'hFFD8FF, 3); minlen = 3; end
      fsc_pkg::TY_JPEG2000: begin
        if (alt) begin
          put_bytes(0, 32'hFF4FFF51, 4); minlen = 4;
        end else begin
          put_bytes(0, 96'h0000000C6A5020200D0A870A, 12); minlen = 12;
        end
      end
      fsc_pkg::TY_JPEGXL: begin
        if (alt) begin
          put_bytes(0, 16'hFF0A, 2); minlen = 2;
        end else begin
          put_bytes(0, 96'h0000000C4A584C200D0A870A, 12); minlen = 12;
        end
      end
      fsc_pkg::TY_JPEGXS: begin put_bytes(0, 32'hFF10FF50, 4); minlen = 4; end
      fsc_pkg::TY_JPEGXR: begin put_bytes(0, 32'h4949BC01, 4); minlen = 4; end
      fsc_pkg::TY_QOI:    begin put_bytes(0, 32'h716F6966, 4); minlen = 4; end
      fsc_pkg::TY_EXR:    begin put_bytes(0, 32'h762F3101, 4); minlen = 4; end
      fsc_pkg::TY_BMP:    begin put_bytes(0, 16'h424D, 2); minlen = 2; end
      fsc_pkg::TY_TIFF: begin
        put_bytes(0, alt ? 32'h49492A00 : 32'h4D4D002A, 4); minlen = 4;
      end
      default: minlen = 1;
    endcase
  endtask

  // random file: mostly well-formed magic numbers with random content,
  // some with one bit flipped within the pattern's span, some plain noise
  task automatic make_file(bit force_opus);
    int                         kind;
    int                         minlen;
    int                         pick;
    int                         pos;
    int                         bitsel;
    logic [fsc_pkg::TYPE_W-1:0] id;
    for (int i = 0; i < 64; i++) fbuf[i] = 8'($urandom_range(0, 255));
    kind = force_opus ? 19 : $urandom_range(0, 19);
    if (kind < 3) begin
      flen = $urandom_range(1, 40);
    end else begin
      id = force_opus ? fsc_pkg::TY_OPUS :
                        fsc_pkg::TYPE_W'($urandom_range(0, fsc_pkg::TYPE_COUNT - 1));
      put_signature(id, minlen);
      // broken magic number: one bit flipped within the pattern's span
      if (kind < 6) begin
        pos    = $urandom_range(0, minlen - 1);
        bitsel = $urandom_range(0, 7);
        fbuf[pos][bitsel] = ~fbuf[pos][bitsel];
      end
      pick = $urandom_range(0, 9);
      if (force_opus)     flen = 44;   // long enough to drop bytes after the verdict
      else if (pick == 0) flen = $urandom_range(1, minlen);   // cut short, zero fill
      else if (pick < 7)  flen = minlen + $urandom_range(0, 6);
      else                flen = $urandom_range(HDR_LEN, HDR_LEN + 12);
    end
  endtask

  // one word on the in channel, after a random gap
  task automatic send_byte(logic [7:0] b, logic eof);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_end_of_file <= eof;
    // hold the word until the edge that takes it
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_file();
    in_burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < flen; i++) send_byte(fbuf[i], i == flen - 1);
  endtask

  // result side: random stall before each word, stretches without stalls
  initial begin
    int stall;
    out_ready <= 1'b0;
    out_burst  = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 7) == 0) out_burst = ~out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 5);
      repeat (stall) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // watchdog: no handshake on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else                                                     quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // stimulus and verdict
  initial begin
    int nfiles;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_data_byte   <= 8'h00;
    in_end_of_file <= 1'b0;
    quiet_cycles    = 0;
    bytes_sent      = 0;
    nfiles          = 0;
    in_burst        = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: short files that lean on the zero fill of unread positions
    put_bytes(0, 8'h00, 1);  flen = 1; send_file();  // all zero, not found
    put_bytes(0, 8'hFF, 1);  flen = 1; send_file();  // lone 0xff, not found
    put_bytes(0, 16'h0001, 2); flen = 2; send_file(); // ttf through zero fill
    put_bytes(0, 16'h424D, 2); flen = 2; send_file(); // bmp
    put_bytes(0, 16'hFF0A, 2); flen = 2; send_file(); // jpeg-xl short form
    put_bytes(0, 16'hFFFB, 2); flen = 2; send_file(); // mp3 frame sync
    put_bytes(0, 16'hFFF9, 2); flen = 2; send_file(); // aac
    put_bytes(0, 32'h4F676753, 4); flen = 4; send_file(); // ogg
    put_bytes(0, 24'h7F80FE, 3); flen = 3; send_file();   // mixed bits, not found

    // random files; the first is opus, which must come back as ogg
    while (bytes_sent < BYTE_GOAL || nfiles < FILE_GOAL) begin
      make_file(nfiles == 0);
      send_file();
      nfiles++;
    end
    in_valid <= 1'b0;

    // drain: every verdict in, then a settle time for stray words
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && verdicts_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
